// File: rtl/bitmap_page_frame_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// bitmap page frame allocator: assertion macros
// shared assertion forms, included only by bpfa_engine among the allocator modules
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// check held at every edge outside reset
`define BPFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("bpfa assertion failed");

// check held at every edge, reset included
`define BPFA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("bpfa assertion failed");

`endif

// File: rtl/bpfa_pkg.sv
// ---------------------------------------------------------------------------
// bpfa_pkg
// types, sizes and codes shared by the page frame allocator modules
// ---------------------------------------------------------------------------
package bpfa_pkg;

    // geometry
    localparam int NUM_PAGES   = 4096;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = NUM_PAGES / WORD_BITS;
    localparam int WORD_AW     = $clog2(NUM_WORDS);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int PAGE_AW     = $clog2(NUM_PAGES);
    localparam int ADDR_W      = 32;
    localparam int START_W     = ADDR_W + 1 - PAGE_SHIFT;
    localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
    localparam int PADDR_OUT_W = 24;
    localparam int COUNT_W     = 13;

    // register port
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_RESERVED_END = 1'b0;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [PADDR_OUT_W-1:0] frame_addr;
        logic [COUNT_W-1:0]     free_pages;
    } rsp_t;

    // bitmap memory command
    typedef struct packed {
        logic                 we;
        logic [WORD_AW-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [WORD_AW-1:0]   raddr;
    } ram_cmd_t;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] idx;
    } zscan_t;

    // lowest clear bit of a bitmap word
    function automatic zscan_t first_zero(input logic [WORD_BITS-1:0] w);
        zscan_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.idx   = BIT_AW'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/bpfa_map_ram.sv
// ---------------------------------------------------------------------------
// bpfa_map_ram
// used-page bitmap storage, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module bpfa_map_ram
    import bpfa_pkg::*;
(
    input  logic                 aclk,
    input  ram_cmd_t             cmd,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    // write port
    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (cmd.re) begin
            rd_data <= mem[cmd.raddr];
        end
    end

endmodule

// File: rtl/bpfa_cfg.sv
// ---------------------------------------------------------------------------
// bpfa_cfg
// apb register file holding the reserved memory end address
// ---------------------------------------------------------------------------
module bpfa_cfg
    import bpfa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [ADDR_W-1:0] reserved_end_addr
);

    logic [ADDR_W-1:0]    resv_reg;
    logic [ADDR_W-1:0]    resv_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // write decode
    always_comb begin
        resv_next = resv_reg;
        if (wr_en && reg_idx == REG_RESERVED_END) begin
            resv_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resv_reg <= '0;
        end else begin
            resv_reg <= resv_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_RESERVED_END: prdata = resv_reg;
            default:          prdata = '0;
        endcase
    end

    assign reserved_end_addr = resv_reg;

endmodule

// File: rtl/bpfa_engine.sv
// ---------------------------------------------------------------------------
// bpfa_engine
// request sequencer: bitmap sweeps, first-fit word scan and free count
// ---------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_core_defines.svh"

module bpfa_engine
    import bpfa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data,
    input  logic [ADDR_W-1:0] reserved_end_addr
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_ACHK  = 3'd3;
    localparam logic [2:0] S_FCHK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    logic [2:0]             state_reg,  state_next;
    logic [WORD_AW-1:0]     widx_reg,   widx_next;
    logic [WORD_AW-1:0]     hint_reg,   hint_next;
    logic [COUNT_W-1:0]     count_reg,  count_next;
    logic [BIT_AW-1:0]      fbit_reg,   fbit_next;
    logic [PAGE_AW-1:0]     start_reg,  start_next;
    logic                   full_reg,   full_next;
    logic [1:0]             status_reg, status_next;
    logic [PADDR_OUT_W-1:0] paddr_reg,  paddr_next;
    logic                   m_valid_reg, m_valid_next;
    rsp_t                   m_data_reg, m_data_next;

    ram_cmd_t             ram_cmd;
    logic [WORD_BITS-1:0] rd_data;
    zscan_t               zs;

    logic [ADDR_W:0]        round_sum;
    logic [START_W-1:0]     start_pg;
    logic                   start_full;
    logic [PAGE_NUM_W-1:0]  fpage;
    logic                   fpage_ok;
    logic [WORD_AW-1:0]     sw;
    logic [BIT_AW-1:0]      sb;
    logic [WORD_BITS-1:0]   init_word;
    logic [PAGE_AW-1:0]     alloc_page;
    logic [ADDR_W-1:0]      alloc_addr;
    logic                   out_free;

    bpfa_map_ram u_map (
        .aclk    (aclk),
        .cmd     (ram_cmd),
        .rd_data (rd_data)
    );

    // first frame boundary at or above the reserved end, no wrap
    assign round_sum  = {1'b0, reserved_end_addr} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    assign start_pg   = round_sum[ADDR_W:PAGE_SHIFT];
    assign start_full = start_pg >= START_W'(NUM_PAGES);

    // page number of a free request
    assign fpage    = s_data.free_addr[ADDR_W-1:PAGE_SHIFT];
    assign fpage_ok = fpage < PAGE_NUM_W'(NUM_PAGES);

    // bitmap word written by the init sweep, 1 marks a used page
    assign sw = start_reg[PAGE_AW-1:BIT_AW];
    assign sb = start_reg[BIT_AW-1:0];
    always_comb begin
        if (full_reg || widx_reg < sw) begin
            init_word = '1;
        end else if (widx_reg > sw) begin
            init_word = '0;
        end else begin
            init_word = ~({WORD_BITS{1'b1}} << sb);
        end
    end

    // word scan unit for the alloc search
    assign zs         = first_zero(rd_data);
    assign alloc_page = {widx_reg, zs.idx};
    assign alloc_addr = ADDR_W'(alloc_page) << PAGE_SHIFT;

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        widx_next    = widx_reg;
        hint_next    = hint_reg;
        count_next   = count_reg;
        fbit_next    = fbit_reg;
        start_next   = start_reg;
        full_next    = full_reg;
        status_next  = status_reg;
        paddr_next   = paddr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_cmd      = '0;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = widx_reg;
                ram_cmd.wdata = '1;
                widx_next     = widx_reg + 1'b1;
                if (widx_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    paddr_next  = '0;
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                    case (s_data.req_type)
                        REQ_ALLOC: begin
                            if (count_reg == '0) begin
                                status_next = ST_OOM;
                            end else begin
                                ram_cmd.re    = 1'b1;
                                ram_cmd.raddr = hint_reg;
                                widx_next     = hint_reg;
                                state_next    = S_ACHK;
                            end
                        end
                        REQ_FREE: begin
                            if (fpage_ok) begin
                                ram_cmd.re    = 1'b1;
                                ram_cmd.raddr = fpage[PAGE_AW-1:BIT_AW];
                                widx_next     = fpage[PAGE_AW-1:BIT_AW];
                                fbit_next     = fpage[BIT_AW-1:0];
                                state_next    = S_FCHK;
                            end
                        end
                        REQ_INIT: begin
                            start_next = start_pg[PAGE_AW-1:0];
                            full_next  = start_full;
                            widx_next  = '0;
                            state_next = S_INIT;
                        end
                        default: begin
                            status_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_INIT: begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = widx_reg;
                ram_cmd.wdata = init_word;
                widx_next     = widx_reg + 1'b1;
                if (widx_reg == LAST_WORD) begin
                    count_next  = full_reg ? '0
                                : COUNT_W'(NUM_PAGES) - COUNT_W'(start_reg);
                    hint_next   = full_reg ? '0 : sw;
                    status_next = ST_DONE;
                    state_next  = S_DONE;
                end
            end
            S_ACHK: begin
                if (zs.found) begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = widx_reg;
                    ram_cmd.wdata = rd_data | (WORD_BITS'(1) << zs.idx);
                    count_next    = count_reg - 1'b1;
                    hint_next     = widx_reg;
                    paddr_next    = alloc_addr[PADDR_OUT_W-1:0];
                    status_next   = ST_DONE;
                    state_next    = S_DONE;
                end else if (widx_reg == LAST_WORD) begin
                    status_next = ST_OOM;
                    state_next  = S_DONE;
                end else begin
                    ram_cmd.re    = 1'b1;
                    ram_cmd.raddr = widx_reg + 1'b1;
                    widx_next     = widx_reg + 1'b1;
                end
            end
            S_FCHK: begin
                if (rd_data[fbit_reg]) begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = widx_reg;
                    ram_cmd.wdata = rd_data & ~(WORD_BITS'(1) << fbit_reg);
                    count_next    = count_reg + 1'b1;
                    if (widx_reg < hint_reg) begin
                        hint_next = widx_reg;
                    end
                    status_next = ST_DONE;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.frame_addr = paddr_reg;
                    m_data_next.free_pages = count_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            widx_reg    <= '0;
            hint_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            widx_reg    <= widx_next;
            hint_reg    <= hint_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        fbit_reg   <= fbit_next;
        start_reg  <= start_next;
        full_reg   <= full_next;
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `BPFA_ASSERT(a_count_range, count_reg <= COUNT_W'(NUM_PAGES))
    `BPFA_ASSERT(a_scan_has_free, state_reg == S_ACHK |-> count_reg != '0)
    `BPFA_ASSERT(a_scan_from_hint, state_reg == S_ACHK |-> widx_reg >= hint_reg)
    `BPFA_ASSERT(a_alloc_dec, state_reg == S_ACHK && zs.found |=>
        count_reg == $past(count_reg) - 1'b1)
    `BPFA_ASSERT_ALWAYS(a_no_accept_busy, s_ready |-> state_reg == S_IDLE)

endmodule

// File: rtl/bitmap_page_frame_allocator_core.sv
// ---------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// first-fit physical page frame allocator with one used bit per page
// ---------------------------------------------------------------------------
//  channel  ports           word      role
//  request  s_valid/s_ready s_data    alloc, free or init request
//  result   m_valid/m_ready m_data    status, page address, free count
//  config   apb (psel...)   pwdata    reserved memory end address
//
//  after reset a clearing pass marks all pages used; s_ready stays low during it
//  alloc: scans bitmap words in turn from the lowest word that
//  may hold a free page (none when the count is zero, else 1 to 128 words)
//  free: bitmap read, check, write back; init: a sweep writing every bitmap word
//  one request in flight; a result held by m_ready stalls only at completion
// ---------------------------------------------------------------------------
module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [ADDR_W-1:0] reserved_end_addr;

    // register file
    bpfa_cfg u_cfg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .reserved_end_addr (reserved_end_addr)
    );

    // allocator sequencer and bitmap
    bpfa_engine u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .reserved_end_addr (reserved_end_addr)
    );

endmodule

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb: page frame allocator testbench
// drives alloc, free, init and unused words into the allocator core, keeps its own
// bitmap and free count to predict every result word, and compares each
// result field by field; the reserved end register is set over apb between
// phases while the core is idle, and both channels idle and stall at random
// ---------------------------------------------------------------------------
module tb
    import bpfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // unused request code, the core must ignore it
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [APB_AW-1:0] RESV_END_ADDR = APB_AW'(4 * REG_RESERVED_END);

    localparam int RAND_ITEMS  = 1200;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    req_t              s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rsp_t              m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    bitmap_page_frame_allocator_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // shadow allocator state
    bit [NUM_PAGES-1:0] frame_used = '1;
    int                 frame_free_cnt = 0;
    logic [31:0]        resv_end = '0;

    req_t req_backlog[$];
    rsp_t pending_results[$];

    int  err_count    = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    bit  calm         = 1'b0;

    // apply one request word to the shadow bitmap and return its result word
    function automatic rsp_t frame_map_step(req_t rq);
        rsp_t            rs;
        longint unsigned first_free;
        longint unsigned page_no;
        rs.status     = ST_IGNORED;
        rs.frame_addr = '0;
        rs.free_pages = '0;
        case (rq.req_type)
            REQ_ALLOC: begin
                rs.status = ST_OOM;
                for (int p = 0; p < NUM_PAGES; p++) begin
                    if (!frame_used[p]) begin
                        frame_used[p] = 1'b1;
                        frame_free_cnt--;
                        rs.frame_addr = PADDR_OUT_W'(p * PAGE_BYTES);
                        rs.status     = ST_DONE;
                        break;
                    end
                end
            end
            REQ_FREE: begin
                page_no = {32'd0, rq.free_addr} >> PAGE_SHIFT;
                if (page_no < NUM_PAGES && frame_used[page_no]) begin
                    frame_used[page_no] = 1'b0;
                    frame_free_cnt++;
                    rs.status = ST_DONE;
                end
            end
            REQ_INIT: begin
                // round up without wrapping at the top of the space
                first_free = ({32'd0, resv_end} + PAGE_BYTES - 1) / PAGE_BYTES;
                frame_free_cnt = 0;
                for (int p = 0; p < NUM_PAGES; p++) begin
                    frame_used[p] = (p < first_free);
                    if (p >= first_free) frame_free_cnt++;
                end
                rs.status = ST_DONE;
            end
            default: ;
        endcase
        rs.free_pages = COUNT_W'(frame_free_cnt);
        return rs;
    endfunction

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // request driver
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) pending_results.push_back(frame_map_step(s_data));
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    s_data  <= req_backlog.pop_front();
                    s_valid <= 1'b1;
                    src_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int snk_stall = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            snk_stall <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with no request pending: %h", $time, m_data);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        err_count++;
                    end
                    if (m_data.frame_addr !== want.frame_addr) begin
                        $display("%0t: frame_addr expected %h actual %h",
                                 $time, want.frame_addr, m_data.frame_addr);
                        err_count++;
                    end
                    if (m_data.free_pages !== want.free_pages) begin
                        $display("%0t: free_pages expected %0d actual %0d",
                                 $time, want.free_pages, m_data.free_pages);
                        err_count++;
                    end
                end
            end
            // one long hold-off so the core backs up into the request side
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (snk_stall > 0) begin
                m_ready   <= 1'b0;
                snk_stall <= snk_stall - 1;
            end else begin
                m_ready   <= 1'b1;
                snk_stall <= pick_gap();
            end
        end
    end

    // one apb transfer, setup then access
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RESV_END_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the reserved end register and read it back
    task automatic set_resv(input logic [31:0] val);
        logic [31:0] rb;
        apb_xfer(1'b1, val, rb);
        apb_xfer(1'b0, '0, rb);
        if (rb !== val) begin
            $display("%0t: reserved_end readback expected %h actual %h", $time, val, rb);
            err_count++;
        end
        resv_end = val;
        @(negedge aclk);
    endtask

    task automatic add_req(input logic [1:0] kind, input logic [31:0] addr);
        req_t r;
        r.req_type  = kind;
        r.free_addr = addr;
        req_backlog.push_back(r);
        items_sent++;
    endtask

    // wait until every request has been answered
    task automatic wait_drained();
        @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic [31:0]     cfg;
        logic [31:0]     addr;
        longint unsigned ceil_pg;
        int              start_pg;
        int              pg;
        int              n;
        int              r;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass after reset
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);

        // directed: reset state has no free frame
        add_req(REQ_ALLOC, 32'h0000_0000);
        add_req(REQ_FREE, 32'h0000_0000);
        // frame zero handed out, address 0 with status done
        add_req(REQ_ALLOC, 32'hFFFF_FFFF);
        add_req(REQ_ALLOC, 32'h0000_0000);
        add_req(REQ_UNUSED, 32'hFFFF_FFFF);
        add_req(REQ_FREE, 32'hFFFF_FFFF);
        add_req(REQ_FREE, 32'h00FF_FFFF);
        add_req(REQ_FREE, 32'h00FF_F000);
        add_req(REQ_FREE, 32'h0100_0000);
        add_req(REQ_INIT, 32'h0000_0000);
        add_req(REQ_ALLOC, 32'h0000_0000);
        add_req(REQ_ALLOC, 32'h0000_0000);
        add_req(REQ_FREE, 32'h0000_1234);
        add_req(REQ_FREE, 32'h0000_1FFF);
        add_req(REQ_ALLOC, 32'h0000_0000);
        wait_drained();

        // end in the last frame of the address space frees nothing
        set_resv(32'hFFFF_FFFF);
        add_req(REQ_INIT, 32'hFFFF_FFFF);
        add_req(REQ_ALLOC, 32'h0000_0000);
        wait_drained();

        // end one byte into the last frame of memory, no frame free
        set_resv(32'h00FF_F001);
        add_req(REQ_INIT, 32'h0000_0000);
        wait_drained();

        // single free frame at the top of memory
        set_resv(32'h00FF_F000);
        add_req(REQ_INIT, 32'h0000_0000);
        add_req(REQ_ALLOC, 32'h0000_0000);
        add_req(REQ_ALLOC, 32'h0000_0000);
        wait_drained();

        // end one byte in, frame zero stays reserved until freed
        set_resv(32'h0000_0001);
        add_req(REQ_INIT, 32'h0000_0000);
        add_req(REQ_ALLOC, 32'h0000_0000);
        add_req(REQ_FREE, 32'h0000_0000);
        add_req(REQ_ALLOC, 32'h0000_0000);
        wait_drained();

        // random phases
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cfg = 32'h0;
                1:       cfg = $urandom;
                2, 3, 4: cfg = (NUM_PAGES - $urandom_range(1, 24)) * PAGE_BYTES
                               - $urandom_range(0, PAGE_BYTES - 1);
                5:       cfg = 32'hFFFF_FFFF - $urandom_range(0, PAGE_BYTES - 1);
                6, 7:    cfg = $urandom_range(0, NUM_PAGES * PAGE_BYTES - 1);
                8:       cfg = $urandom_range(0, NUM_PAGES) * PAGE_BYTES;
                default: cfg = $urandom_range(0, 3 * PAGE_BYTES);
            endcase
            set_resv(cfg);
            ceil_pg  = ({32'd0, cfg} + PAGE_BYTES - 1) / PAGE_BYTES;
            start_pg = (ceil_pg > NUM_PAGES) ? NUM_PAGES : int'(ceil_pg);
            calm     = ($urandom_range(0, 3) == 0);

            n = $urandom_range(20, 90);
            if ($urandom_range(0, 9) != 0) add_req(REQ_INIT, $urandom);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    add_req(REQ_ALLOC, $urandom);
                end else if (r < 80) begin
                    // mostly frames near the allocation front
                    case ($urandom_range(0, 9))
                        6:       pg = $urandom_range(0, NUM_PAGES - 1);
                        7:       pg = $urandom_range(0, start_pg);
                        8, 9:    pg = -1;
                        default: pg = start_pg - 4 + $urandom_range(0, 40);
                    endcase
                    if (pg == -1) begin
                        addr = ($urandom_range(0, 1) == 0) ? $urandom
                             : NUM_PAGES * PAGE_BYTES + $urandom_range(0, 2 * PAGE_BYTES);
                    end else begin
                        if (pg < 0) pg = 0;
                        if (pg > NUM_PAGES - 1) pg = NUM_PAGES - 1;
                        addr = (pg << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
                    end
                    add_req(REQ_FREE, addr);
                end else if (r < 87) begin
                    add_req(REQ_INIT, $urandom);
                end else if (r < 93) begin
                    add_req(REQ_UNUSED, $urandom);
                end else begin
                    add_req(REQ_ALLOC, $urandom);
                end
            end
            wait_drained();
        end

        repeat (50) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
